[hdl/bbr_pkg.sv]
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared widths, register codes, reciprocal table and types of the row blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int CH_W       = 8;
    localparam int SUM_W      = 14;
    localparam int RAD_W      = 5;
    localparam int DIV_W      = RAD_W + 1;
    localparam int COL_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // floor(s / d) = (s * ceil(2^SH / d)) >> SH, exact for s < 2^SUM_W and d < 64
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int QUO_W    = PROD_W - RECIP_SH;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CRED_W     = 4;

    localparam logic [CH_W-1:0]       CH_MAX        = 8'd255;
    localparam logic [COL_W-1:0]      ROW_WIDTH_RST = 16'd640;
    localparam logic [RAD_W-1:0]      RADIUS_RST    = 5'd1;
    localparam logic [RAD_W-1:0]      RAD_TOP       = 5'd31;

    localparam logic [CFG_IDX_W-1:0]  REG_ROW_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_BLUR_RADIUS = 8'd1;

    localparam logic [RECIP_W-1:0] RECIP_ONE = 21'h100000;

    // indexed by radius r, divisor 2r+1
    localparam logic [RECIP_W-1:0] RECIP_TAB [2**RAD_W] = '{
        (RECIP_ONE + 21'd0)  / 21'd1,  (RECIP_ONE + 21'd2)  / 21'd3,
        (RECIP_ONE + 21'd4)  / 21'd5,  (RECIP_ONE + 21'd6)  / 21'd7,
        (RECIP_ONE + 21'd8)  / 21'd9,  (RECIP_ONE + 21'd10) / 21'd11,
        (RECIP_ONE + 21'd12) / 21'd13, (RECIP_ONE + 21'd14) / 21'd15,
        (RECIP_ONE + 21'd16) / 21'd17, (RECIP_ONE + 21'd18) / 21'd19,
        (RECIP_ONE + 21'd20) / 21'd21, (RECIP_ONE + 21'd22) / 21'd23,
        (RECIP_ONE + 21'd24) / 21'd25, (RECIP_ONE + 21'd26) / 21'd27,
        (RECIP_ONE + 21'd28) / 21'd29, (RECIP_ONE + 21'd30) / 21'd31,
        (RECIP_ONE + 21'd32) / 21'd33, (RECIP_ONE + 21'd34) / 21'd35,
        (RECIP_ONE + 21'd36) / 21'd37, (RECIP_ONE + 21'd38) / 21'd39,
        (RECIP_ONE + 21'd40) / 21'd41, (RECIP_ONE + 21'd42) / 21'd43,
        (RECIP_ONE + 21'd44) / 21'd45, (RECIP_ONE + 21'd46) / 21'd47,
        (RECIP_ONE + 21'd48) / 21'd49, (RECIP_ONE + 21'd50) / 21'd51,
        (RECIP_ONE + 21'd52) / 21'd53, (RECIP_ONE + 21'd54) / 21'd55,
        (RECIP_ONE + 21'd56) / 21'd57, (RECIP_ONE + 21'd58) / 21'd59,
        (RECIP_ONE + 21'd60) / 21'd61, (RECIP_ONE + 21'd62) / 21'd63
    };

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic valid;
        logic init;
        logic emit;
        logic last;
    } t_lane_ctl;

    typedef struct packed {
        logic valid;
        logic last;
    } t_res_ctl;

    typedef struct packed {
        t_lane_ctl        ctl;
        logic             use_mem;
        logic [RAD_W-1:0] rad;
        t_pixel           add_px;
        t_pixel           sub_px;
    } t_op;

endpackage

[hdl/bbr_if.sv]
// ----------------------------------------------------------------------------
// bbr_if
// Handshake channels of the row blur: pixel in, pixel out, register write.
// ----------------------------------------------------------------------------
interface bbr_pix_in_if import bbr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface bbr_pix_out_if import bbr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            row_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output row_end, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input row_end, output ready);
endinterface

interface bbr_cfg_if import bbr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/bbr_lane.sv]
// ----------------------------------------------------------------------------
// bbr_lane
// One color channel: running window sum, then divide by 2r+1 through a
// reciprocal multiply, clamp to 8 bits.
// ----------------------------------------------------------------------------
module bbr_lane import bbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  logic [RAD_W-1:0] i_rad,
    input  logic [CH_W-1:0]  i_add,
    input  logic [CH_W-1:0]  i_sub,
    output t_res_ctl         o_res,
    output logic [CH_W-1:0]  o_quo
);

    logic [DIV_W-1:0]  span;
    logic [SUM_W-1:0]  init_sum;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    t_res_ctl          r_s2;
    t_res_ctl          r_s3;
    logic [RAD_W-1:0]  r_s2_rad;
    logic [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]  quo_full;

    assign span     = {i_rad, 1'b1};
    assign init_sum = SUM_W'(SUM_W'(span) * SUM_W'(i_add));

    // first pixel of a row fills the whole window; otherwise slide by one
    assign n_sum = i_ctl.init ? init_sum
                              : SUM_W'(r_sum + SUM_W'(i_add) - SUM_W'(i_sub));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_s2  <= '0;
            r_s3  <= '0;
        end else begin
            if (i_ctl.valid) begin
                r_sum <= n_sum;
            end
            r_s2.valid <= i_ctl.valid & i_ctl.emit;
            r_s2.last  <= i_ctl.last;
            r_s3       <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_rad <= i_rad;
        r_prod   <= PROD_W'(r_sum) * PROD_W'(RECIP_TAB[r_s2_rad]);
    end

    assign quo_full = r_prod[PROD_W-1:RECIP_SH];
    assign o_quo    = (quo_full > QUO_W'(CH_MAX)) ? CH_MAX : quo_full[CH_W-1:0];
    assign o_res    = r_s3;

endmodule

[hdl/bbr_merge.sv]
// ----------------------------------------------------------------------------
// bbr_merge
// Join the three lane quotients into one output word and queue it for the
// output channel.
// ----------------------------------------------------------------------------
module bbr_merge import bbr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_res_ctl        i_res,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    bbr_pix_out_if.source   o_pix
);

    typedef struct packed {
        t_pixel px;
        logic   last;
    } t_out_word;

    t_out_word            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [CRED_W-1:0]    r_cnt;
    logic                 push;
    logic                 pop;
    t_out_word            head;

    // the issue side holds a credit for every word, so push never overflows
    assign push = i_res.valid;
    assign pop  = o_pix.valid & o_pix.ready;
    assign head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{px: '{red: i_red, green: i_green, blue: i_blue},
                               last: i_res.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CRED_W'(push) - CRED_W'(pop);
        end
    end

    assign o_pix.valid     = (r_cnt != '0);
    assign o_pix.red_out   = head.px.red;
    assign o_pix.green_out = head.px.green;
    assign o_pix.blue_out  = head.px.blue;
    assign o_pix.row_end   = head.last;

endmodule

[hdl/box_blur_row_rgb.sv]
// ----------------------------------------------------------------------------
// box_blur_row_rgb
// Horizontal box blur of RGB rows with edge replication.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  word
//  i_pix    in   red_in, green_in, blue_in                one pixel
//  o_pix    out  red_out, green_out, blue_out, row_end    one blurred pixel
//  i_cfg    in   index, data                              one register write
//
//  One pixel is taken per clock when not stalled; results pass the issue
//  and lane registers to the output queue. The last pixel of a row is
//  followed by r flush words (one memory read each) with i_pix.ready low.
//  An 8-word output queue absorbs output stalls; when it is committed full,
//  input stalls. Reset is synchronous; the window memory needs no clear.
// ----------------------------------------------------------------------------
module box_blur_row_rgb import bbr_pkg::*; #(
    parameter int MAX_RADIUS   = 31,
    parameter int WINDOW_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bbr_pix_in_if.sink     i_pix,
    bbr_pix_out_if.source  o_pix,
    bbr_cfg_if.sink        i_cfg
);

    localparam int WIN_AW   = $clog2(WINDOW_DEPTH);
    localparam int RAD_WIN  = (WINDOW_DEPTH - 2) / 2;
    localparam int RAD_LIM0 = (MAX_RADIUS < RAD_WIN) ? MAX_RADIUS : RAD_WIN;
    localparam int RAD_LIM  = (RAD_LIM0 < 2**RAD_W - 1) ? RAD_LIM0 : 2**RAD_W - 1;
    localparam logic [RAD_W-1:0]  RAD_CAP  = RAD_W'(RAD_LIM);
    localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_DEPTH - 1);
    localparam logic [WIN_AW:0]   WIN_SIZE = (WIN_AW+1)'(WINDOW_DEPTH);

    // configuration
    logic [COL_W-1:0]  r_row_width;
    logic [RAD_W-1:0]  r_blur_rad;

    // row state
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  r_act_w;
    logic [RAD_W-1:0]  r_act_r;
    t_pixel            r_first;
    logic              r_flushing;
    logic [RAD_W-1:0]  r_left;
    logic [WIN_AW-1:0] r_fptr;
    t_pixel            r_px;
    logic [WIN_AW-1:0] r_wptr;
    logic [CRED_W-1:0] r_credit;
    t_op               r_op;
    t_op               n_op;

    // window memory
    t_pixel            r_win [WINDOW_DEPTH];
    t_pixel            r_rdata;

    t_pixel            px;
    t_pixel            sub_px;
    logic              col_zero;
    logic [COL_W-1:0]  w_eff;
    logic [COL_W-1:0]  half;
    logic [RAD_W-1:0]  rad_new;
    logic [COL_W-1:0]  cur_w;
    logic [RAD_W-1:0]  cur_r;
    logic [DIV_W-1:0]  span;
    logic              use_mem;
    logic              end_row;
    logic              emit;
    logic              last;
    logic              credit_ok;
    logic              in_acc;
    logic              fl_issue;
    logic              issue_emit;
    logic              out_pop;
    logic [WIN_AW:0]   rd_raw;
    logic [WIN_AW-1:0] rd_norm;
    logic [WIN_AW-1:0] rd_addr;
    t_res_ctl          red_res;
    logic [CH_W-1:0]   red_q;
    logic [CH_W-1:0]   green_q;
    logic [CH_W-1:0]   blue_q;

    function automatic logic [WIN_AW-1:0] wrap_inc(input logic [WIN_AW-1:0] p);
        return (p == WIN_LAST) ? '0 : p + 1'b1;
    endfunction

    // configuration port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_blur_rad  <= RADIUS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROW_WIDTH: begin
                    r_row_width <= i_cfg.data[COL_W-1:0];
                end
                REG_BLUR_RADIUS: begin
                    r_blur_rad <= i_cfg.data[RAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // row setup, latched on the first pixel of each row
    assign px       = '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};
    assign col_zero = (r_col == '0);
    assign w_eff    = (r_row_width == '0) ? COL_W'(1) : r_row_width;
    assign half     = (w_eff - COL_W'(1)) >> 1;

    always_comb begin
        rad_new = r_blur_rad;
        if (COL_W'(rad_new) > half) begin
            rad_new = half[RAD_W-1:0];
        end
        if (rad_new > RAD_CAP) begin
            rad_new = RAD_CAP;
        end
    end

    assign cur_w   = col_zero ? w_eff : r_act_w;
    assign cur_r   = col_zero ? rad_new : r_act_r;
    assign span    = {r_act_r, 1'b1};
    assign use_mem = !col_zero && (r_col >= COL_W'(span));
    assign end_row = (r_col >= cur_w - COL_W'(1));
    assign emit    = (r_col >= COL_W'(cur_r));
    assign last    = end_row && (cur_r == '0);

    // handshake and credits for the output queue
    assign credit_ok   = (r_credit != CRED_W'(FIFO_DEPTH));
    assign i_pix.ready = !r_flushing && credit_ok;
    assign in_acc      = i_pix.valid & i_pix.ready;
    assign fl_issue    = r_flushing & credit_ok;
    assign issue_emit  = (in_acc & emit) | fl_issue;
    assign out_pop     = o_pix.valid & o_pix.ready;

    // slot of column c - 2r - 1, modulo the window depth
    assign rd_raw  = {1'b0, r_wptr} + WIN_SIZE - (WIN_AW+1)'(span);
    assign rd_norm = (rd_raw >= WIN_SIZE) ? WIN_AW'(rd_raw - WIN_SIZE) : rd_raw[WIN_AW-1:0];
    assign rd_addr = r_flushing ? r_fptr : rd_norm;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win[r_wptr] <= px;
        end
        r_rdata <= r_win[rd_addr];
    end

    always_comb begin
        n_op = '0;
        if (in_acc) begin
            n_op.ctl     = '{valid: 1'b1, init: col_zero, emit: emit, last: last};
            n_op.use_mem = use_mem;
            n_op.rad     = cur_r;
            n_op.add_px  = px;
            n_op.sub_px  = r_first;
        end else if (fl_issue) begin
            n_op.ctl     = '{valid: 1'b1, init: 1'b0, emit: 1'b1,
                             last: (r_left == RAD_W'(1))};
            n_op.use_mem = 1'b1;
            n_op.rad     = r_act_r;
            n_op.add_px  = r_px;
            n_op.sub_px  = r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_act_w    <= COL_W'(1);
            r_act_r    <= '0;
            r_first    <= '0;
            r_flushing <= 1'b0;
            r_left     <= '0;
            r_fptr     <= '0;
            r_px       <= '0;
            r_wptr     <= '0;
            r_credit   <= '0;
            r_op       <= '0;
        end else begin
            r_op     <= n_op;
            r_credit <= r_credit + CRED_W'(issue_emit) - CRED_W'(out_pop);
            if (in_acc) begin
                if (col_zero) begin
                    r_act_w <= w_eff;
                    r_act_r <= rad_new;
                    r_first <= px;
                end
                if (end_row) begin
                    r_col  <= '0;
                    r_wptr <= '0;
                    if (cur_r != '0) begin
                        r_flushing <= 1'b1;
                        r_left     <= cur_r;
                        r_fptr     <= wrap_inc(rd_norm);
                        r_px       <= px;
                    end
                end else begin
                    r_col  <= r_col + COL_W'(1);
                    r_wptr <= wrap_inc(r_wptr);
                end
            end else if (fl_issue) begin
                // replicate the last pixel past the right edge
                r_fptr <= wrap_inc(r_fptr);
                r_left <= r_left - RAD_W'(1);
                if (r_left == RAD_W'(1)) begin
                    r_flushing <= 1'b0;
                end
            end
        end
    end

    assign sub_px = r_op.use_mem ? r_rdata : r_op.sub_px;

    bbr_lane u_lane_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_op.ctl),
        .i_rad   (r_op.rad),
        .i_add   (r_op.add_px.red),
        .i_sub   (sub_px.red),
        .o_res   (red_res),
        .o_quo   (red_q)
    );

    bbr_lane u_lane_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_op.ctl),
        .i_rad   (r_op.rad),
        .i_add   (r_op.add_px.green),
        .i_sub   (sub_px.green),
        .o_res   (),
        .o_quo   (green_q)
    );

    bbr_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_op.ctl),
        .i_rad   (r_op.rad),
        .i_add   (r_op.add_px.blue),
        .i_sub   (sub_px.blue),
        .o_res   (),
        .o_quo   (blue_q)
    );

    bbr_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (red_res),
        .i_red   (red_q),
        .i_green (green_q),
        .i_blue  (blue_q),
        .o_pix   (o_pix)
    );

endmodule

[test/bbr_row_blur_check.sv]
// ----------------------------------------------------------------------------
// bbr_row_blur_check
// Watches the pixel, result and register channels of the row blur. Keeps its
// own copy of the registers and window state, works out the blurred words
// that every accepted pixel completes and compares each accepted output word,
// field by field, against the oldest word still due.
// ----------------------------------------------------------------------------
module bbr_row_blur_check import bbr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bbr_pix_in_if  i_pix,
    bbr_pix_out_if o_pix,
    bbr_cfg_if     i_cfg,
    output int     o_mismatches,
    output int     o_words_due
);

    localparam int MAX_RAD   = 31;
    localparam int WIN_SLOTS = 64;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            row_end;
    } t_blurred;

    t_pixel           win_mem [WIN_SLOTS];
    logic [SUM_W-1:0] acc_red;
    logic [SUM_W-1:0] acc_green;
    logic [SUM_W-1:0] acc_blue;
    t_pixel           row_first;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] width_reg;
    logic [RAD_W-1:0] radius_reg;
    int unsigned      row_len;
    int unsigned      row_rad;

    t_blurred blurred_due [$];
    t_blurred want;
    t_pixel   px_seen;
    int       mismatch_count = 0;
    int       due_words = 0;

    assign o_mismatches = mismatch_count;
    assign o_words_due  = due_words;

    task automatic report_mismatch(input string msg);
        $display("%0t blur mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic slide_sums(input t_pixel add_px, input t_pixel sub_px);
        acc_red   = acc_red + add_px.red - sub_px.red;
        acc_green = acc_green + add_px.green - sub_px.green;
        acc_blue  = acc_blue + add_px.blue - sub_px.blue;
    endtask

    function automatic logic [CH_W-1:0] mean_of(input logic [SUM_W-1:0] acc);
        int unsigned q;
        q = acc / (2 * row_rad + 1);
        return (q > CH_MAX) ? CH_MAX : q[CH_W-1:0];
    endfunction

    task automatic push_mean(input logic last);
        blurred_due.push_back(t_blurred'{mean_of(acc_red), mean_of(acc_green),
                                         mean_of(acc_blue), last});
    endtask

    task automatic blur_next_pixel(input t_pixel px);
        int unsigned c;
        int unsigned r;
        int unsigned w;
        int unsigned x;
        t_pixel      old;
        c = 32'(col_next);
        if (c == 0) begin
            // latch width and radius for the whole row
            w = (width_reg == '0) ? 1 : 32'(width_reg);
            r = 32'(radius_reg);
            if (r > (w - 1) / 2) r = (w - 1) / 2;
            if (r > MAX_RAD) r = MAX_RAD;
            if (r > (WIN_SLOTS - 2) / 2) r = (WIN_SLOTS - 2) / 2;
            row_len   = w;
            row_rad   = r;
            row_first = px;
            acc_red   = SUM_W'((2 * r + 1) * px.red);
            acc_green = SUM_W'((2 * r + 1) * px.green);
            acc_blue  = SUM_W'((2 * r + 1) * px.blue);
        end else begin
            r = row_rad;
            // left of the row the first pixel stands in
            old = (c >= 2 * r + 1) ? win_mem[(c - 2 * r - 1) % WIN_SLOTS] : row_first;
            slide_sums(px, old);
        end
        win_mem[c % WIN_SLOTS] = px;
        if (c >= r) push_mean(c == row_len - 1 && r == 0);
        if (c >= row_len - 1) begin
            // flush: the last pixel repeats beyond the right edge
            for (x = row_len - r; x < row_len; x++) begin
                slide_sums(px, win_mem[(x - r - 1) % WIN_SLOTS]);
                push_mean(x == row_len - 1);
            end
            col_next = '0;
        end else begin
            col_next = COL_W'(c + 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_red    = '0;
            acc_green  = '0;
            acc_blue   = '0;
            row_first  = '0;
            col_next   = '0;
            width_reg  = ROW_WIDTH_RST;
            radius_reg = RADIUS_RST;
            row_len    = 1;
            row_rad    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ROW_WIDTH:   width_reg = i_cfg.data;
                    REG_BLUR_RADIUS: radius_reg = i_cfg.data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                px_seen = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
                blur_next_pixel(px_seen);
            end
            if (o_pix.valid && o_pix.ready) begin
                if (blurred_due.size() == 0) begin
                    report_mismatch($sformatf("word with none due: %0d %0d %0d end %0b",
                                              o_pix.red_out, o_pix.green_out,
                                              o_pix.blue_out, o_pix.row_end));
                end else begin
                    want = blurred_due.pop_front();
                    if (o_pix.red_out !== want.red)
                        report_mismatch($sformatf("red got %0d want %0d",
                                                  o_pix.red_out, want.red));
                    if (o_pix.green_out !== want.green)
                        report_mismatch($sformatf("green got %0d want %0d",
                                                  o_pix.green_out, want.green));
                    if (o_pix.blue_out !== want.blue)
                        report_mismatch($sformatf("blue got %0d want %0d",
                                                  o_pix.blue_out, want.blue));
                    if (o_pix.row_end !== want.row_end)
                        report_mismatch($sformatf("row_end got %0b want %0b",
                                                  o_pix.row_end, want.row_end));
                end
            end
        end
        due_words = blurred_due.size();
    end

endmodule

[test/tb_box_blur_row_rgb.sv]
// ----------------------------------------------------------------------------
// tb_box_blur_row_rgb
// Drives the row blur with a short directed set of rows (single-pixel rows,
// width zero, radius clamping, unused register indexes, a register write in
// the middle of a row), a long output hold-off that backs up the input, then
// random rows of random widths and radii up to a fixed item budget.
// Input bursts and output stalls are random; checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_box_blur_row_rgb import bbr_pkg::*; ();

    localparam int LIMIT_TIME    = 10_000_000;
    localparam int RST_CYCLES    = 4;
    localparam int TOTAL_ITEMS   = 260;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 80;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = REG_BLUR_RADIUS + 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_FREE  = '1;

    typedef enum int {RX_OPEN, RX_COIN, RX_BEAT} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bbr_pix_in_if  pix_in ();
    bbr_pix_out_if pix_out ();
    bbr_cfg_if     cfg ();

    int mismatch_total;
    int words_due;

    bit                    hold_req   = 1'b0;
    int                    burst_left = 0;
    int                    gap_top    = 3;
    int                    row_left   = 0;
    int                    width_set  = 640;
    int                    items_sent = 0;
    int                    pick;
    int                    count;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CFG_IDX_W-1:0]  reg_idx_q [$];
    logic [CFG_DATA_W-1:0] reg_val_q [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    box_blur_row_rgb u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg)
    );

    bbr_row_blur_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_in),
        .o_pix        (pix_out),
        .i_cfg        (cfg),
        .o_mismatches (mismatch_total),
        .o_words_due  (words_due)
    );

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_idx_q.push_back(idx);
        reg_val_q.push_back(val);
    endtask

    // back-to-back writes keep valid high; drop it once the list is empty
    task automatic write_regs();
        while (reg_idx_q.size() != 0) begin
            cfg.valid = 1'b1;
            cfg.index = reg_idx_q.pop_front();
            cfg.data  = reg_val_q.pop_front();
            do @(posedge i_clk); while (!cfg.ready);
            @(negedge i_clk);
            if (cfg.index == REG_ROW_WIDTH) width_set = (cfg.data == '0) ? 1 : 32'(cfg.data);
        end
        cfg.valid = 1'b0;
    endtask

    task automatic send_pixel(input t_pixel px);
        int gap;
        pix_in.valid    = 1'b1;
        pix_in.red_in   = px.red;
        pix_in.green_in = px.green;
        pix_in.blue_in  = px.blue;
        do @(posedge i_clk); while (!pix_in.ready);
        @(negedge i_clk);
        items_sent++;
        if (row_left == 0) row_left = width_set;
        row_left--;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(12, 0);
            gap = $urandom_range(gap_top, 0);
            if (gap > 0) begin
                pix_in.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    function automatic t_pixel pick_pixel(input bit extremes);
        t_pixel px;
        px = t_pixel'($urandom);
        if (extremes) begin
            px.red   = $urandom_range(1, 0) ? CH_MAX : '0;
            px.green = $urandom_range(1, 0) ? CH_MAX : '0;
            px.blue  = $urandom_range(1, 0) ? CH_MAX : '0;
        end
        return px;
    endfunction

    task automatic send_pixels(input int n, input bit extremes);
        repeat (n) send_pixel(pick_pixel(extremes));
    endtask

    // hold until every due word is out, then let a flush in flight finish
    task automatic drain();
        pix_in.valid = 1'b0;
        while (words_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        t_rx_mode seg_mode;
        int       seg_left;
        int       tick;
        seg_mode      = RX_OPEN;
        seg_left      = 0;
        tick          = 0;
        pix_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pix_out.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = t_rx_mode'($urandom_range(2, 0));
                    seg_left = $urandom_range(60, 10);
                end
                seg_left--;
                tick++;
                case (seg_mode)
                    RX_OPEN: pix_out.ready = 1'b1;
                    RX_COIN: pix_out.ready = 1'($urandom_range(1, 0));
                    default: pix_out.ready = (tick % 4 != 0);
                endcase
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("[box_blur_row_rgb] ERROR");
        $finish;
    end

    initial begin
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one-pixel rows
        queue_reg(REG_ROW_WIDTH, 16'd1);
        queue_reg(REG_BLUR_RADIUS, 16'd0);
        write_regs();
        send_pixel(t_pixel'{CH_MAX, CH_MAX, CH_MAX});
        drain();

        // width zero acts as one, radius clamps to zero
        queue_reg(REG_ROW_WIDTH, 16'd0);
        queue_reg(REG_BLUR_RADIUS, 16'd31);
        write_regs();
        send_pixel(t_pixel'{8'd0, CH_MAX, 8'd0});
        drain();

        // unused indexes must change nothing
        queue_reg(REG_FIRST_FREE, '1);
        queue_reg(REG_LAST_FREE, '1);
        queue_reg(REG_ROW_WIDTH, 16'd3);
        queue_reg(REG_BLUR_RADIUS, 16'd1);
        write_regs();
        send_pixel(t_pixel'{CH_MAX, 8'd0, 8'd128});
        send_pixel(t_pixel'{8'd0, CH_MAX, 8'd1});
        send_pixel(t_pixel'{CH_MAX, CH_MAX, CH_MAX});
        drain();

        queue_reg(REG_ROW_WIDTH, 16'd2);
        queue_reg(REG_BLUR_RADIUS, 16'd5);
        write_regs();
        send_pixel(t_pixel'{8'd0, 8'd0, 8'd0});
        send_pixel(t_pixel'{CH_MAX, CH_MAX, CH_MAX});
        drain();

        // radius at the width limit
        queue_reg(REG_ROW_WIDTH, 16'd5);
        queue_reg(REG_BLUR_RADIUS, 16'd2);
        write_regs();
        send_pixel(t_pixel'{CH_MAX, 8'd0, CH_MAX});
        send_pixel(t_pixel'{8'd0, CH_MAX, 8'd0});
        send_pixel(t_pixel'{CH_MAX, 8'd0, CH_MAX});
        send_pixel(t_pixel'{8'd0, CH_MAX, 8'd0});
        send_pixel(t_pixel'{CH_MAX, 8'd0, CH_MAX});
        drain();

        // a write mid-row only takes hold at the next row
        queue_reg(REG_ROW_WIDTH, 16'd6);
        queue_reg(REG_BLUR_RADIUS, 16'hFFE1);
        write_regs();
        send_pixels(3, 1'b1);
        drain();
        queue_reg(REG_ROW_WIDTH, 16'd4);
        queue_reg(REG_BLUR_RADIUS, 16'd0);
        write_regs();
        send_pixels(7, 1'b0);
        drain();

        // output held off while input streams: the block must back up
        queue_reg(REG_ROW_WIDTH, 16'd40);
        queue_reg(REG_BLUR_RADIUS, 16'd3);
        write_regs();
        hold_req = 1'b1;
        gap_top  = 0;
        send_pixels(40, 1'b0);
        drain();

        // widest window the memory allows
        queue_reg(REG_ROW_WIDTH, 16'd63);
        queue_reg(REG_BLUR_RADIUS, 16'd31);
        write_regs();
        gap_top = 3;
        send_pixels(63, 1'b1);
        send_pixels(63, 1'b0);
        drain();

        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(3, 0) != 0) begin
                pick = $urandom_range(9, 0);
                if (pick == 0) count = 0;
                else if (pick <= 6) count = $urandom_range(12, 1);
                else if (pick <= 8) count = $urandom_range(40, 13);
                else count = $urandom_range(70, 63);
                queue_reg(REG_ROW_WIDTH, CFG_DATA_W'(count));
            end
            if ($urandom_range(3, 0) != 0) begin
                reg_val = CFG_DATA_W'($urandom);
                if ($urandom_range(3, 0) == 0) reg_val[RAD_W-1:0] = '1;
                queue_reg(REG_BLUR_RADIUS, reg_val);
            end
            if ($urandom_range(7, 0) == 0) begin
                queue_reg(CFG_IDX_W'($urandom_range(REG_LAST_FREE, REG_FIRST_FREE)),
                          CFG_DATA_W'($urandom));
            end
            write_regs();
            gap_top = $urandom_range(6, 0);
            if ($urandom_range(4, 0) == 0) count = $urandom_range(width_set, 1);
            else count = row_left + width_set * $urandom_range(2, 1);
            // stay near the item budget
            if (count > TOTAL_ITEMS - items_sent) count = TOTAL_ITEMS - items_sent;
            send_pixels(count, $urandom_range(3, 0) == 0);
            drain();
        end

        // close any open row
        if (row_left != 0) begin
            send_pixels(row_left, 1'b0);
            drain();
        end

        if (mismatch_total == 0 && words_due == 0) begin
            $display("[box_blur_row_rgb] OK");
        end else begin
            $display("[box_blur_row_rgb] ERROR");
        end
        $finish;
    end

endmodule
